// ===== src/epsw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package epsw_pkg;

   localparam int PAGE_BYTES_DEFAULT = 32;
   localparam int FAIL_LIMIT         = 3;

   localparam int ADDR_W   = 16;
   localparam int OFS_W    = 8;
   localparam int LEN_W    = 7;
   localparam int RLEN_W   = 8;
   localparam int FAIL_W   = 3;
   localparam int COUNT_W  = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [1:0] {
      RS_IDLE  = 2'd0,
      RS_WAIT  = 2'd1,
      RS_WRITE = 2'd2,
      RS_ERROR = 2'd3
   } rec_state_type;

   typedef enum logic [1:0] {
      PH_FIRST  = 2'd0,
      PH_MIDDLE = 2'd1,
      PH_FINAL  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      STS_OK          = 2'd0,
      STS_PENDING     = 2'd1,
      STS_PENDING_ERR = 2'd2,
      STS_INVALID     = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STORE_READY  = 3'd0,
      CSR_REC0_ADDRESS = 3'd1,
      CSR_REC0_LENGTH  = 3'd2,
      CSR_REC1_ADDRESS = 3'd3,
      CSR_REC1_LENGTH  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic load_item;
      logic div_mul;
      logic div_fix;
      logic div_on_rem;
      logic exec;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_split;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== src/epsw_channels.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface epsw_req_if;
   import epsw_pkg::*;
   logic valid;
   logic ready;
   logic action;
   logic record_sel;
   logic data_changed;
   logic write_ok;
   modport source (output valid, action, record_sel, data_changed, write_ok, input ready);
   modport sink   (input valid, action, record_sel, data_changed, write_ok, output ready);
endinterface

interface epsw_rsp_if;
   import epsw_pkg::*;
   logic              valid;
   logic              ready;
   logic              write_valid;
   logic [ADDR_W-1:0] write_address;
   logic [OFS_W-1:0]  write_offset;
   logic [LEN_W-1:0]  write_length;
   logic [1:0]        request_status;
   logic [1:0]        record_state;
   logic              busy_res;
   modport source (output valid, write_valid, write_address, write_offset, write_length,
                   request_status, record_state, busy_res, input ready);
   modport sink   (input valid, write_valid, write_address, write_offset, write_length,
                   request_status, record_state, busy_res, output ready);
endinterface

`default_nettype wire

// ===== src/epsw_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module epsw_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  epsw_pkg::dp_status_type status,
   output epsw_pkg::ctrl_cmd_type  cmd
);
   import epsw_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_ADDR_MUL = 6'b000010,
      S_ADDR_FIX = 6'b000100,
      S_REM_MUL  = 6'b001000,
      S_REM_FIX  = 6'b010000,
      S_EXEC     = 6'b100000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      in_ready = 1'b0;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load_item = 1'b1;
               state_in = status.need_split ? S_ADDR_MUL : S_EXEC;
            end
         end
         S_ADDR_MUL: begin
            cmd.div_mul = 1'b1;
            state_in    = S_ADDR_FIX;
         end
         S_ADDR_FIX: begin
            cmd.div_fix = 1'b1;
            state_in    = S_REM_MUL;
         end
         S_REM_MUL: begin
            cmd.div_mul    = 1'b1;
            cmd.div_on_rem = 1'b1;
            state_in       = S_REM_FIX;
         end
         S_REM_FIX: begin
            cmd.div_fix    = 1'b1;
            cmd.div_on_rem = 1'b1;
            state_in       = S_EXEC;
         end
         S_EXEC: begin
            // wait for the output register to free up
            if (status.out_free) begin
               cmd.exec = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== src/epsw_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module epsw_dp #(
   parameter int PAGE_BYTES = epsw_pkg::PAGE_BYTES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  epsw_pkg::ctrl_cmd_type              cmd,
   output epsw_pkg::dp_status_type             status,
   input  logic                                req_action,
   input  logic                                req_record_sel,
   input  logic                                req_data_changed,
   input  logic                                req_write_ok,
   input  logic                                csr_we,
   input  logic [epsw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [epsw_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic                                rsp_write_valid,
   output logic [epsw_pkg::ADDR_W-1:0]         rsp_write_address,
   output logic [epsw_pkg::OFS_W-1:0]          rsp_write_offset,
   output logic [epsw_pkg::LEN_W-1:0]          rsp_write_length,
   output logic [1:0]                          rsp_request_status,
   output logic [1:0]                          rsp_record_state,
   output logic                                rsp_busy_res
);
   import epsw_pkg::*;

   localparam int PB_W      = $clog2(PAGE_BYTES + 1);
   localparam int R_W       = PB_W + 1;
   localparam int DIV_SHIFT = ADDR_W;
   localparam int RECIP     = (1 << DIV_SHIFT) / PAGE_BYTES;
   localparam int RECIP_W   = $clog2(RECIP + 1);
   localparam int PROD_W    = ADDR_W + RECIP_W;
   localparam logic [PB_W-1:0] PB = PB_W'(PAGE_BYTES);

   // configuration
   logic              store_ready_ff;
   logic [ADDR_W-1:0] rec0_address_ff, rec1_address_ff;
   logic [RLEN_W-1:0] rec0_length_ff, rec1_length_ff;

   // record and queue state
   rec_state_type      rec_state_ff [2];
   logic               queue_ff [2];
   logic [COUNT_W-1:0] count_ff;
   phase_type          phase_ff;
   logic [ADDR_W-1:0]  cur_address_ff;
   logic [OFS_W-1:0]   cur_offset_ff;
   logic [RLEN_W-1:0]  pages_left_ff;
   logic [LEN_W-1:0]   tail_bytes_ff;
   logic [FAIL_W-1:0]  fail_count_ff;
   logic               busy_ff;

   // latched word
   logic item_action_ff, item_sel_ff, item_changed_ff, item_ok_ff;

   // divider
   logic [PROD_W-1:0]  mul_ff;
   logic [PB_W-1:0]    first_ff;
   logic               longer_ff;
   logic [RLEN_W-1:0]  rem_ff;
   logic [RLEN_W-1:0]  pages_calc_ff;
   logic [LEN_W-1:0]   tail_calc_ff;

   logic [ADDR_W-1:0]  div_dividend;
   logic [RECIP_W-1:0] q_est;
   logic [PROD_W-1:0]  r_diff;
   logic [R_W-1:0]     r_raw;
   logic               fix_up;
   logic [PB_W-1:0]    r_val;
   logic [RECIP_W-1:0] q_val;
   logic [PB_W-1:0]    first_val;

   logic               head;
   logic [ADDR_W-1:0]  head_addr;
   logic [RLEN_W-1:0]  head_len;

   // next-state values
   rec_state_type      rs_n [2];
   logic               q_n [2];
   logic [COUNT_W-1:0] cnt_n;
   phase_type          ph_n;
   logic [ADDR_W-1:0]  ca_n;
   logic [OFS_W-1:0]   co_n;
   logic [RLEN_W-1:0]  pl_n;
   logic [LEN_W-1:0]   tb_n;
   logic [FAIL_W-1:0]  fc_n;
   logic               busy_n;
   logic               wv;
   logic [ADDR_W-1:0]  wa;
   logic [OFS_W-1:0]   wo;
   logic [LEN_W-1:0]   wl;
   status_type         sts;
   rec_state_type      st;
   logic               found, failed, dequeue;

   assign head      = queue_ff[0];
   assign head_addr = head ? rec1_address_ff : rec0_address_ff;
   assign head_len  = head ? rec1_length_ff : rec0_length_ff;

   assign status.need_split = !req_action && store_ready_ff && (count_ff != '0)
                              && (phase_ff != PH_MIDDLE) && (phase_ff != PH_FINAL);
   assign status.out_free   = !rsp_valid || rsp_ready;

   // shared reciprocal divider: estimate, then one correcting subtract
   assign div_dividend = cmd.div_on_rem ? ADDR_W'(rem_ff) : head_addr;
   assign q_est  = mul_ff[PROD_W-1:DIV_SHIFT];
   assign r_diff = PROD_W'(div_dividend) - PROD_W'(q_est) * PROD_W'(PAGE_BYTES);
   assign r_raw  = r_diff[R_W-1:0];
   assign fix_up = (r_raw >= R_W'(PAGE_BYTES));
   assign r_val  = fix_up ? PB_W'(r_raw - R_W'(PAGE_BYTES)) : PB_W'(r_raw);
   assign q_val  = q_est + RECIP_W'(fix_up);
   assign first_val = PB - r_val;

   always_ff @(posedge clock) begin
      if (cmd.div_mul) begin
         mul_ff <= PROD_W'(div_dividend) * PROD_W'(RECIP);
      end
      if (cmd.div_fix && !cmd.div_on_rem) begin
         first_ff  <= first_val;
         longer_ff <= head_len > RLEN_W'(first_val);
         rem_ff    <= head_len - RLEN_W'(first_val);
      end
      if (cmd.div_fix && cmd.div_on_rem) begin
         pages_calc_ff <= longer_ff ? RLEN_W'(q_val) : '0;
         tail_calc_ff  <= longer_ff ? LEN_W'(r_val) : '0;
      end
      if (cmd.load_item) begin
         item_action_ff  <= req_action;
         item_sel_ff     <= req_record_sel;
         item_changed_ff <= req_data_changed;
         item_ok_ff      <= req_write_ok;
      end
   end

   always_comb begin
      rs_n   = rec_state_ff;
      q_n    = queue_ff;
      cnt_n  = count_ff;
      ph_n   = phase_ff;
      ca_n   = cur_address_ff;
      co_n   = cur_offset_ff;
      pl_n   = pages_left_ff;
      tb_n   = tail_bytes_ff;
      fc_n   = fail_count_ff;
      busy_n = busy_ff;
      wv     = 1'b0;
      wa     = '0;
      wo     = '0;
      wl     = '0;
      sts    = STS_OK;
      st     = rec_state_ff[item_sel_ff];
      found  = 1'b0;
      failed = 1'b0;
      dequeue = 1'b0;
      if (item_action_ff) begin
         if (!store_ready_ff) begin
            sts = STS_INVALID;
         end else if (st == RS_WRITE) begin
            sts = STS_PENDING;
         end else if (!item_changed_ff) begin
            sts = STS_OK;
         end else begin
            found = ((count_ff >= 2'd1) && (queue_ff[0] == item_sel_ff))
                 || ((count_ff >= 2'd2) && (queue_ff[1] == item_sel_ff));
            if (!found && (count_ff >= 2'd2)) begin
               sts = STS_INVALID;
            end else begin
               if (!found) begin
                  q_n[count_ff[0]] = item_sel_ff;
                  cnt_n = count_ff + 2'd1;
               end
               rs_n[item_sel_ff] = RS_WAIT;
               sts = (st == RS_ERROR) ? STS_PENDING_ERR : STS_PENDING;
            end
         end
      end else if (store_ready_ff) begin
         if (count_ff == '0) begin
            busy_n = 1'b0;
         end else begin
            busy_n = 1'b1;
            case (phase_ff)
               PH_MIDDLE: begin
                  if (pages_left_ff != '0) begin
                     wv = 1'b1;
                     wa = cur_address_ff;
                     wo = cur_offset_ff;
                     wl = LEN_W'(PAGE_BYTES);
                     if (item_ok_ff) begin
                        pl_n = pages_left_ff - 8'd1;
                        ca_n = cur_address_ff + ADDR_W'(PAGE_BYTES);
                        co_n = cur_offset_ff + OFS_W'(PAGE_BYTES);
                     end else begin
                        failed = 1'b1;
                     end
                  end
                  if (!failed) begin
                     fc_n = '0;
                     if (pl_n == '0) begin
                        if (tail_bytes_ff != '0) begin
                           ph_n = PH_FINAL;
                        end else begin
                           ph_n = PH_FIRST;
                           rs_n[head] = RS_IDLE;
                           dequeue = 1'b1;
                        end
                     end
                  end
               end
               PH_FINAL: begin
                  if (tail_bytes_ff != '0) begin
                     wv = 1'b1;
                     wa = cur_address_ff;
                     wo = cur_offset_ff;
                     wl = tail_bytes_ff;
                     failed = !item_ok_ff;
                  end
                  if (!failed) begin
                     fc_n = '0;
                     ph_n = PH_FIRST;
                     rs_n[head] = RS_IDLE;
                     dequeue = 1'b1;
                  end
               end
               default: begin
                  ph_n = PH_FIRST;
                  rs_n[head] = RS_WRITE;
                  co_n = '0;
                  ca_n = head_addr;
                  pl_n = pages_calc_ff;
                  tb_n = tail_calc_ff;
                  wv = 1'b1;
                  wa = head_addr;
                  wo = '0;
                  wl = longer_ff ? LEN_W'(first_ff) : head_len[LEN_W-1:0];
                  if (!item_ok_ff) begin
                     failed = 1'b1;
                  end else begin
                     fc_n = '0;
                     if (!longer_ff) begin
                        rs_n[head] = RS_IDLE;
                        dequeue = 1'b1;
                     end else begin
                        ca_n = head_addr + ADDR_W'(first_ff);
                        co_n = OFS_W'(first_ff);
                        ph_n = (pages_calc_ff != '0) ? PH_MIDDLE : PH_FINAL;
                     end
                  end
               end
            endcase
            if (failed) begin
               fc_n = fail_count_ff + 3'd1;
               if (fc_n > FAIL_W'(FAIL_LIMIT)) begin
                  fc_n = '0;
                  ph_n = PH_FIRST;
                  rs_n[head] = RS_ERROR;
                  dequeue = 1'b1;
               end
            end
            if (dequeue) begin
               q_n[0] = queue_ff[1];
               cnt_n  = count_ff - 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ready_ff  <= 1'b0;
         rec0_address_ff <= '0;
         rec0_length_ff  <= 8'd1;
         rec1_address_ff <= '0;
         rec1_length_ff  <= 8'd1;
         rec_state_ff[0] <= RS_IDLE;
         rec_state_ff[1] <= RS_IDLE;
         count_ff        <= '0;
         phase_ff        <= PH_FIRST;
         cur_address_ff  <= '0;
         cur_offset_ff   <= '0;
         pages_left_ff   <= '0;
         tail_bytes_ff   <= '0;
         fail_count_ff   <= '0;
         busy_ff         <= 1'b0;
         rsp_valid       <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_STORE_READY:  store_ready_ff  <= csr_data[0];
               CSR_REC0_ADDRESS: rec0_address_ff <= csr_data[ADDR_W-1:0];
               CSR_REC0_LENGTH:  rec0_length_ff  <= csr_data[RLEN_W-1:0];
               CSR_REC1_ADDRESS: rec1_address_ff <= csr_data[ADDR_W-1:0];
               CSR_REC1_LENGTH:  rec1_length_ff  <= csr_data[RLEN_W-1:0];
               default: ;
            endcase
         end
         if (cmd.exec) begin
            rec_state_ff[0] <= rs_n[0];
            rec_state_ff[1] <= rs_n[1];
            count_ff        <= cnt_n;
            phase_ff        <= ph_n;
            cur_address_ff  <= ca_n;
            cur_offset_ff   <= co_n;
            pages_left_ff   <= pl_n;
            tail_bytes_ff   <= tb_n;
            fail_count_ff   <= fc_n;
            busy_ff         <= busy_n;
            rsp_valid       <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid       <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         queue_ff[0]        <= q_n[0];
         queue_ff[1]        <= q_n[1];
         rsp_write_valid    <= wv;
         rsp_write_address  <= wa;
         rsp_write_offset   <= wo;
         rsp_write_length   <= wl;
         rsp_request_status <= sts;
         rsp_record_state   <= rs_n[item_sel_ff];
         rsp_busy_res       <= busy_n;
      end
   end

endmodule

`default_nettype wire

// ===== src/eeprom_page_split_write_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Page-split write queue for two EEPROM records. Each word on req is either a
// write request (action = 1) for record_sel, or a tick (action = 0) that serves
// the head of a two-entry queue and issues at most one page write; every word
// yields exactly one word on rsp. A word that needs no page split (a request, a
// tick while the store is down or the queue is empty, or a tick in the middle
// or final phase) goes from acceptance straight to the commit state. A tick that
// starts a record (first page, including retries) first passes the states
// S_ADDR_MUL, S_ADDR_FIX, S_REM_MUL and S_REM_FIX, where the first partial
// page and the page/tail split are computed by one shared reciprocal divider
// that runs twice, a multiply step and a correction step each time. The
// commit holds for as long as the previous result still waits on rsp.ready.
// Input is taken again the cycle after a result is loaded, even while that
// result still waits on rsp.ready. Configuration registers are written
// through csr_we/csr_index/csr_data; the user must write them only while no
// word is in flight, and the block itself does not enforce it.

module eeprom_page_split_write_queue #(
   parameter int PAGE_BYTES = epsw_pkg::PAGE_BYTES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   epsw_req_if.sink                        req,
   epsw_rsp_if.source                      rsp,
   input  logic                            csr_we,
   input  logic [epsw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [epsw_pkg::CSR_DATA_W-1:0] csr_data
);
   import epsw_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          in_ready;

   assign req.ready = in_ready;

   // sequencer: accept, run the divider when a record starts, then commit
   epsw_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req.valid),
      .in_ready (in_ready),
      .status   (status),
      .cmd      (cmd)
   );

   // record state, queue, page split arithmetic and the result register
   epsw_dp #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_action         (req.action),
      .req_record_sel     (req.record_sel),
      .req_data_changed   (req.data_changed),
      .req_write_ok       (req.write_ok),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_ready          (rsp.ready),
      .rsp_valid          (rsp.valid),
      .rsp_write_valid    (rsp.write_valid),
      .rsp_write_address  (rsp.write_address),
      .rsp_write_offset   (rsp.write_offset),
      .rsp_write_length   (rsp.write_length),
      .rsp_request_status (rsp.request_status),
      .rsp_record_state   (rsp.record_state),
      .rsp_busy_res       (rsp.busy_res)
   );

   // commit only into a free result register
   a_exec_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> status.out_free)
      else $error("commit while result register is occupied");

   // one word in flight: drop ready right after acceptance
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("second word accepted while one is in flight");

   // a commit always produces a result on the next cycle
   a_exec_gives_result: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> rsp.valid)
      else $error("commit did not load a result");

   // the address divide step is always followed by its correction step
   a_div_order: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_mul && !cmd.div_on_rem) |=> (cmd.div_fix && !cmd.div_on_rem))
      else $error("divider sequence broken");

   // at most one controller command per cycle
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_item, cmd.div_mul, cmd.div_fix, cmd.exec}))
      else $error("overlapping controller commands");

endmodule

`default_nettype wire
